### src/dagetp_pkg.sv
package dagetp_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int TIME_WIDTH = 32;

    localparam int NodeW = 10;
    localparam int ValW  = 32;
    localparam int CmdW  = 2;
    localparam int AddrW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SumW  = ((TIME_WIDTH > ValW) ? TIME_WIDTH : ValW) + 1;

    localparam logic [CmdW-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CmdW-1:0] CMD_RELAX = 2'd1;
    localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

    typedef logic signed [TIME_WIDTH-1:0] t_time;
    typedef logic signed [SumW-1:0]       t_wide;
    typedef logic [NodeW-1:0]             t_node;

    localparam t_wide TimeMaxWide = t_wide'({1'b0, {(TIME_WIDTH-1){1'b1}}});
    localparam t_wide TimeMinWide = -TimeMaxWide - t_wide'(1);

    function automatic t_time clamp_load(input logic signed [ValW-1:0] tv);
        t_wide v;
        v = t_wide'(tv);
        if (v > TimeMaxWide) begin
            return t_time'(TimeMaxWide);
        end else if (v < TimeMinWide) begin
            return t_time'(TimeMinWide);
        end
        return t_time'(v);
    endfunction

endpackage

### src/dag_event_time_propagation_core.sv
// Channel  Direction  Handshake                  Payload
// input    in         i_in_valid / o_in_ready    i_command, i_node, i_pred, i_time_value
// result   out        o_out_valid / i_out_ready  o_realized_time, o_cause_node,
//                                                o_updated, o_saturated
// Each item passes a read step and an execute step: the input transfer issues the memory
// reads, and the execute step computes the relaxation, writes the node back and loads the
// output register. The reads of the time and cause memories are registered.
// Reset clears the control state only; the memories hold undefined data until loaded.
// While the output register holds an untaken result, the execute step waits; a new input
// transfer is still taken whenever the execute step is free.
module dag_event_time_propagation_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [dagetp_pkg::CmdW-1:0]            i_command,
    input  logic [dagetp_pkg::NodeW-1:0]           i_node,
    input  logic [dagetp_pkg::NodeW-1:0]           i_pred,
    input  logic signed [dagetp_pkg::ValW-1:0]     i_time_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [dagetp_pkg::ValW-1:0]     o_realized_time,
    output logic [dagetp_pkg::NodeW-1:0]           o_cause_node,
    output logic                                   o_updated,
    output logic                                   o_saturated
);
    import dagetp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    t_time mem_time  [NODE_COUNT];
    t_node mem_cause [NODE_COUNT];

    logic                   r_state;
    logic                   n_state;
    logic [CmdW-1:0]        r_cmd;
    logic [AddrW-1:0]       r_node_addr;
    t_node                  r_node;
    t_node                  r_pred;
    logic signed [ValW-1:0] r_tv;
    logic                   r_node_ok;
    logic                   r_pred_ok;
    t_time                  r_time_n;
    t_time                  r_time_p;
    t_node                  r_cause_n;

    logic                   r_out_valid;
    logic signed [ValW-1:0] r_out_time;
    t_node                  r_out_cause;
    logic                   r_out_upd;
    logic                   r_out_sat;

    logic                   in_fire;
    logic                   exec_fire;
    logic                   node_ok;
    logic                   pred_ok;
    t_wide                  sum;
    t_time                  relax_time;
    logic                   relax_sat;
    logic                   relax_win;
    logic                   wr_en;
    t_time                  wr_time;
    t_node                  wr_cause;
    t_time                  res_time;
    t_node                  res_cause;
    logic                   res_upd;
    logic                   res_sat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign exec_fire  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign node_ok    = (32'(i_node) < NODE_COUNT);
    assign pred_ok    = (32'(i_pred) < NODE_COUNT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        sum = t_wide'(r_time_p) + t_wide'(r_tv);
        if (sum > TimeMaxWide) begin
            relax_time = t_time'(TimeMaxWide);
            relax_sat  = 1'b1;
        end else if (sum < TimeMinWide) begin
            relax_time = t_time'(TimeMinWide);
            relax_sat  = 1'b1;
        end else begin
            relax_time = t_time'(sum);
            relax_sat  = 1'b0;
        end
        relax_win = relax_time > r_time_n;

        wr_en     = 1'b0;
        wr_time   = clamp_load(r_tv);
        wr_cause  = r_node;
        res_time  = r_time_n;
        res_cause = r_cause_n;
        res_upd   = 1'b0;
        res_sat   = 1'b0;
        case (r_cmd)
            CMD_LOAD: begin
                wr_en     = 1'b1;
                res_time  = wr_time;
                res_cause = r_node;
                res_upd   = 1'b1;
            end
            CMD_RELAX: begin
                if (r_pred_ok) begin
                    res_sat = relax_sat;
                    if (relax_win) begin
                        wr_en     = 1'b1;
                        wr_time   = relax_time;
                        wr_cause  = r_pred;
                        res_time  = relax_time;
                        res_cause = r_pred;
                        res_upd   = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                res_upd = 1'b0;
            end
            default: begin
                res_upd = 1'b0;
            end
        endcase
        if (!r_node_ok) begin
            wr_en     = 1'b0;
            res_time  = '0;
            res_cause = '0;
            res_upd   = 1'b0;
            res_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_time_n  <= mem_time[AddrW'(i_node)];
            r_time_p  <= mem_time[AddrW'(i_pred)];
            r_cause_n <= mem_cause[AddrW'(i_node)];
        end
        if (exec_fire && wr_en) begin
            mem_time[r_node_addr]  <= wr_time;
            mem_cause[r_node_addr] <= wr_cause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd       <= i_command;
            r_node_addr <= AddrW'(i_node);
            r_node      <= i_node;
            r_pred      <= i_pred;
            r_tv        <= i_time_value;
            r_node_ok   <= node_ok;
            r_pred_ok   <= pred_ok;
        end
        if (exec_fire) begin
            r_out_time  <= ValW'(t_wide'(res_time));
            r_out_cause <= res_cause;
            r_out_upd   <= res_upd;
            r_out_sat   <= res_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_realized_time = r_out_time;
    assign o_cause_node    = r_out_cause;
    assign o_updated       = r_out_upd;
    assign o_saturated     = r_out_sat;

    // An accepted item always moves on to the execute step.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted item did not enter the execute step");

    // The execute step holds while the output register is full and stalled.
    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && r_out_valid && !i_out_ready) |=>
        ((r_state == S_EXEC) && o_out_valid))
        else $error("execute step left while the result was stalled");

    // A load of a node in range always reports an update without saturation.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && (r_cmd == CMD_LOAD) && r_node_ok) |=>
        (o_out_valid && o_updated && !o_saturated))
        else $error("load result flags are wrong");

    // Saturation is only ever reported for a relaxation.
    a_sat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && (r_cmd != CMD_RELAX)) |=> !o_saturated)
        else $error("saturation reported for an item that is not a relaxation");

endmodule

### tb/sv/dag_event_time_propagation_core_test.sv
module dag_event_time_propagation_core_test;
    import dagetp_pkg::*;

    localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
    localparam t_time TIME_MAX = 32'sh7FFF_FFFF;
    localparam t_time TIME_MIN = 32'sh8000_0000;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_PER_PHASE = 317;
    localparam int DIRECTED_ROWS = 17;
    localparam int PEND_DEPTH = 16;

    typedef struct packed {
        t_time at;
        t_node cause;
        logic  upd;
        logic  sat;
    } event_result_t;

    typedef struct packed {
        logic [CmdW-1:0] cmd;
        t_node           node;
        t_node           pred;
        t_time           value;
        logic            typed;
        event_result_t   want;
    } stim_row_t;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [CmdW-1:0] i_command;
    t_node           i_node;
    t_node           i_pred;
    t_time           i_time_value;
    logic            o_out_valid;
    logic            i_out_ready;
    t_time           o_realized_time;
    t_node           o_cause_node;
    logic            o_updated;
    logic            o_saturated;

    t_time         node_times [NODE_COUNT];
    t_node         node_causes [NODE_COUNT];
    bit            node_loaded [NODE_COUNT];
    t_node         loaded_nodes [NODE_COUNT];
    int            loaded_count = 0;
    event_result_t pending_results [PEND_DEPTH];
    int            pend_wr = 0;
    int            pend_rd = 0;
    int            result_mismatches = 0;
    int            cycle_count = 0;
    int            gap_pct = 9;
    int            stall_pct = 47;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_LOAD, 10'd0, 10'd0, 32'sd0, 1'b1, '{32'sd0, 10'd0, 1'b1, 1'b0}},
        '{CMD_LOAD, 10'd1023, 10'd1023, TIME_MAX, 1'b1, '{TIME_MAX, 10'd1023, 1'b1, 1'b0}},
        '{CMD_LOAD, 10'd512, 10'd0, TIME_MIN, 1'b1, '{TIME_MIN, 10'd512, 1'b1, 1'b0}},
        '{CMD_LOAD, 10'd341, 10'd682, 32'sh0001_0000, 1'b1,
          '{32'sh0001_0000, 10'd341, 1'b1, 1'b0}},
        '{CMD_LOAD, 10'd682, 10'd341, -32'sd1, 1'b1, '{-32'sd1, 10'd682, 1'b1, 1'b0}},
        '{CMD_RELAX, 10'd0, 10'd1023, 32'sd1, 1'b1, '{TIME_MAX, 10'd1023, 1'b1, 1'b1}},
        '{CMD_RELAX, 10'd0, 10'd1023, 32'sd5, 1'b1, '{TIME_MAX, 10'd1023, 1'b0, 1'b1}},
        '{CMD_RELAX, 10'd512, 10'd512, -32'sd1, 1'b1, '{TIME_MIN, 10'd512, 1'b0, 1'b1}},
        '{CMD_RELAX, 10'd682, 10'd341, 32'sd0, 1'b0, '0},
        '{CMD_LOAD, 10'd100, 10'd1023, 32'sd10, 1'b1, '{32'sd10, 10'd100, 1'b1, 1'b0}},
        '{CMD_RELAX, 10'd682, 10'd100, 32'sd65526, 1'b0, '0},
        '{CMD_READ, 10'd682, 10'd0, 32'sd0, 1'b0, '0},
        '{CMD_SPARE, 10'd1023, 10'd512, -32'sd7, 1'b0, '0},
        '{CMD_RELAX, 10'd1023, 10'd512, TIME_MAX, 1'b0, '0},
        '{CMD_RELAX, 10'd512, 10'd512, TIME_MIN, 1'b0, '0},
        '{CMD_RELAX, 10'd341, 10'd341, 32'sd3, 1'b0, '0},
        '{CMD_READ, 10'd341, 10'd1023, 32'sh5555_AAAA, 1'b0, '0}
    };

    dag_event_time_propagation_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_node         (i_node),
        .i_pred         (i_pred),
        .i_time_value   (i_time_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_realized_time(o_realized_time),
        .o_cause_node   (o_cause_node),
        .o_updated      (o_updated),
        .o_saturated    (o_saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic event_result_t propagate_time(input logic [CmdW-1:0] cmd,
                                                     input t_node node, input t_node pred,
                                                     input t_time value);
        event_result_t    r;
        logic signed [32:0] sum;
        t_time            cand;
        r = '0;
        if (cmd == CMD_LOAD) begin
            node_times[node] = value;
            node_causes[node] = node;
            r.upd = 1'b1;
            if (!node_loaded[node]) begin
                node_loaded[node] = 1'b1;
                loaded_nodes[AddrW'(loaded_count)] = node;
                loaded_count++;
            end
        end else if (cmd == CMD_RELAX) begin
            sum = {node_times[pred][31], node_times[pred]} + {value[31], value};
            if (sum[32] != sum[31]) begin
                r.sat = 1'b1;
                cand = sum[32] ? TIME_MIN : TIME_MAX;
            end else begin
                cand = sum[31:0];
            end
            if (cand > node_times[node]) begin
                node_times[node] = cand;
                node_causes[node] = pred;
                r.upd = 1'b1;
            end
        end
        r.at = node_times[node];
        r.cause = node_causes[node];
        return r;
    endfunction

    task automatic post_event(input logic [CmdW-1:0] cmd, input t_node node,
                              input t_node pred, input t_time value, input logic typed,
                              input event_result_t want);
        event_result_t r;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_node <= node;
        i_pred <= pred;
        i_time_value <= value;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        r = propagate_time(cmd, node, pred, value);
        pending_results[pend_wr[3:0]] = typed ? want : r;
        pend_wr++;
    endtask

    function automatic t_time pick_delay();
        case ($urandom_range(0, 9))
            0: return t_time'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return TIME_MAX;
                    1: return TIME_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            2, 3: return -t_time'($urandom_range(0, 32'h0003_0000));
            4, 5: return t_time'($urandom_range(0, 4) << 16);
            default: return t_time'($urandom_range(0, 32'h0004_0000));
        endcase
    endfunction

    function automatic t_node pick_known();
        int span;
        span = loaded_count;
        if ($urandom_range(0, 1) == 0 && span > 8) begin
            return loaded_nodes[AddrW'(span - 1 - int'($urandom_range(0, 7)))];
        end
        return loaded_nodes[AddrW'($urandom_range(0, span - 1))];
    endfunction

    task automatic post_random_event();
        int    roll;
        t_node node;
        t_node pred;
        roll = $urandom_range(0, 99);
        pred = t_node'($urandom);
        if (loaded_count < 4 || roll < 20) begin
            if (loaded_count < 64 || $urandom_range(0, 2) == 0) begin
                node = t_node'($urandom);
            end else begin
                node = pick_known();
            end
            post_event(CMD_LOAD, node, pred, pick_delay(), 1'b0, '0);
        end else if (roll < 82) begin
            node = pick_known();
            pred = pick_known();
            post_event(CMD_RELAX, node, pred, pick_delay(), 1'b0, '0);
        end else begin
            post_event($urandom_range(0, 1) ? CMD_READ : CMD_SPARE, pick_known(), pred,
                       t_time'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        event_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pend_wr == pend_rd) begin
                result_mismatches++;
                if (result_mismatches <= 10) begin
                    $display("Unexpected result: time %h cause %0d updated %b saturated %b",
                             o_realized_time, o_cause_node, o_updated, o_saturated);
                end
            end else begin
                want = pending_results[pend_rd[3:0]];
                pend_rd++;
                if (o_realized_time !== want.at || o_cause_node !== want.cause
                        || o_updated !== want.upd || o_saturated !== want.sat) begin
                    result_mismatches++;
                    if (result_mismatches <= 10) begin
                        $display("Mismatch: expected time %h cause %0d updated %b saturated %b",
                                 want.at, want.cause, want.upd, want.sat);
                        $display("          actual   time %h cause %0d updated %b saturated %b",
                                 o_realized_time, o_cause_node, o_updated, o_saturated);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_out_ready <= 1'b0;
        i_command <= CMD_READ;
        i_node <= '0;
        i_pred <= '0;
        i_time_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 9 : (phase == 1) ? 47 : 0;
            stall_pct = (phase == 0) ? 47 : (phase == 1) ? 9 : 0;
            if (phase == 0) begin
                foreach (directed_rows[k]) begin
                    post_event(directed_rows[k].cmd, directed_rows[k].node,
                               directed_rows[k].pred, directed_rows[k].value,
                               directed_rows[k].typed, directed_rows[k].want);
                end
            end
            repeat (RANDOM_PER_PHASE) post_random_event();
        end

        i_in_valid <= 1'b0;
        while (pend_wr != pend_rd) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (result_mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
src/dagetp_pkg.sv
src/dag_event_time_propagation_core.sv
tb/sv/dag_event_time_propagation_core_test.sv
